// ===== rtl/core/cgpg_pkg.sv =====
// ----------------------------------------------------------------------------
// cgpg_pkg
// Shared constants, register map and the quarter-wave |cos| table of the
// cosine grating pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cgpg_pkg;

    // Raster and phase geometry
    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = 13;                  // width of frame size registers
    localparam int CNT_W       = 12;                  // column / row counters
    localparam int PHASE_BITS  = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int R_BITS      = $clog2(TABLE_DEPTH);
    localparam int PIX_W       = 8;

    // Configuration port
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_T1_STEP_X    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_T1_STEP_Y    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_T2_STEP_X    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_T2_STEP_Y    = 3'd6;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // Fixed-point cosine table construction (Q30)
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                   64'd90, 64'd132, 64'd182};

    typedef logic [PIX_W-1:0] t_cos_table [TABLE_DEPTH];

    // Horner-form Taylor series, every product truncated to Q30
    function automatic t_cos_table build_cos_table();
        t_cos_table      tbl;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned d;
        for (int r = 0; r < TABLE_DEPTH; r++) begin
            u  = (PI_HALF_Q30 * longint'(r)) / TABLE_DEPTH;
            u2 = (u * u) >> 30;
            t  = Q30_ONE;
            for (int k = 7; k >= 1; k--) begin
                d = ((u2 * t) >> 30) / TAYLOR_DIV[k-1];
                t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
            end
            tbl[r] = PIX_W'((64'd255 * t) >> 30);
        end
        return tbl;
    endfunction

    localparam t_cos_table COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

// ===== rtl/core/cgpg_cos_lut.sv =====
// ----------------------------------------------------------------------------
// cgpg_cos_lut
// Phase to floor(255*|cos|) through the quarter-wave table, folded by quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_cos_lut (
    input  wire logic [cgpg_pkg::PHASE_BITS-1:0] i_phase,
    output logic      [cgpg_pkg::PIX_W-1:0]      o_mag
);

    localparam int QUAD_LSB = cgpg_pkg::PHASE_BITS - 2;
    localparam int R_MSB    = cgpg_pkg::PHASE_BITS - 3;
    localparam int RB       = cgpg_pkg::R_BITS;

    logic                          odd_quad;
    logic [cgpg_pkg::R_BITS-1:0]   r_idx;
    logic [cgpg_pkg::R_BITS-1:0]   mirror_idx;

    assign odd_quad   = i_phase[QUAD_LSB];
    assign r_idx      = i_phase[R_MSB -: cgpg_pkg::R_BITS];
    assign mirror_idx = RB'(cgpg_pkg::TABLE_DEPTH - int'(r_idx));

    // Odd quadrants read the table mirrored; their first point is a zero crossing
    always_comb begin
        if (!odd_quad) begin
            o_mag = cgpg_pkg::COS_TABLE[r_idx];
        end else if (r_idx == '0) begin
            o_mag = '0;
        end else begin
            o_mag = cgpg_pkg::COS_TABLE[mirror_idx];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cosine_grating_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// cosine_grating_pattern_generator
// Raster-scan cosine grating test pattern source, one pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: each accepted item requests one pixel; tdata bit 0 is
//   restart, which starts a new frame at pixel (0,0) with all phases zero.
//   Master stream: one item per request. tdata = {row, column, pixel},
//   tlast marks the last pixel of a row, tuser the last pixel of the frame.
//   APB port: seven registers at byte addresses 0x00..0x18 (mode, frame
//   width, frame height, term-one x/y step, term-two x/y step). pready is
//   always high; writes should land only while the stream is idle.
// Latency and throughput:
//   A pixel appears on the master side in the cycle after its request is
//   accepted. One item per cycle is sustained while the receiver keeps
//   tready high: the raster state, the two table lookups and the averaging
//   adder all complete between the state registers and the output register.
// Reset:
//   Synchronous, active low. Clears the raster counters and phases, empties
//   the output register and loads the register defaults (640x480, mode 0).
// Stall:
//   While a pixel is held with tready low, the output register keeps it and
//   the slave side stops accepting; the raster does not advance.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_grating_pattern_generator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [0] restart
    // pixel stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [31:0]                            o_m_tdata,   // [7:0] pixel,
                                                                // [19:8] column,
                                                                // [31:20] row
    output logic                                   o_m_tlast,   // end_of_line
    output logic                                   o_m_tuser,   // end_of_frame
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cgpg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [cgpg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [cgpg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int PB    = cgpg_pkg::PHASE_BITS;
    localparam int CW    = cgpg_pkg::CNT_W;
    localparam int DW    = cgpg_pkg::DIM_W;
    localparam int PW    = cgpg_pkg::PIX_W;
    localparam int DATAW = cgpg_pkg::CFG_DATA_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                               r_mode;
    logic [DW-1:0]                      r_frame_width;
    logic [DW-1:0]                      r_frame_height;
    logic [PB-1:0]                      r_t1_step_x;
    logic [PB-1:0]                      r_t1_step_y;
    logic [PB-1:0]                      r_t2_step_x;
    logic [PB-1:0]                      r_t2_step_y;

    logic                               cfg_wr;
    logic [cgpg_pkg::REG_IDX_W-1:0]     reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[cgpg_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_frame_width  <= cgpg_pkg::WIDTH_RESET;
            r_frame_height <= cgpg_pkg::HEIGHT_RESET;
            r_t1_step_x    <= '0;
            r_t1_step_y    <= '0;
            r_t2_step_x    <= '0;
            r_t2_step_y    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cgpg_pkg::REG_MODE:         r_mode         <= pwdata[0];
                cgpg_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DW-1:0];
                cgpg_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[DW-1:0];
                cgpg_pkg::REG_T1_STEP_X:    r_t1_step_x    <= pwdata[PB-1:0];
                cgpg_pkg::REG_T1_STEP_Y:    r_t1_step_y    <= pwdata[PB-1:0];
                cgpg_pkg::REG_T2_STEP_X:    r_t2_step_x    <= pwdata[PB-1:0];
                cgpg_pkg::REG_T2_STEP_Y:    r_t2_step_y    <= pwdata[PB-1:0];
                default: ;                  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cgpg_pkg::REG_MODE:         prdata = DATAW'(r_mode);
            cgpg_pkg::REG_FRAME_WIDTH:  prdata = DATAW'(r_frame_width);
            cgpg_pkg::REG_FRAME_HEIGHT: prdata = DATAW'(r_frame_height);
            cgpg_pkg::REG_T1_STEP_X:    prdata = DATAW'(r_t1_step_x);
            cgpg_pkg::REG_T1_STEP_Y:    prdata = DATAW'(r_t1_step_y);
            cgpg_pkg::REG_T2_STEP_X:    prdata = DATAW'(r_t2_step_x);
            cgpg_pkg::REG_T2_STEP_Y:    prdata = DATAW'(r_t2_step_y);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size: zero acts as one, oversize clamps to MAX_DIM
    // ------------------------------------------------------------------
    logic [CW-1:0] last_col;
    logic [CW-1:0] last_row;

    function automatic logic [CW-1:0] last_index(input logic [DW-1:0] dim);
        logic [CW-1:0] idx;
        if (dim == '0) begin
            idx = '0;
        end else if (dim > DW'(cgpg_pkg::MAX_DIM)) begin
            idx = CW'(cgpg_pkg::MAX_DIM - 1);
        end else begin
            idx = CW'(dim - DW'(1));
        end
        return idx;
    endfunction

    assign last_col = last_index(r_frame_width);
    assign last_row = last_index(r_frame_height);

    // ------------------------------------------------------------------
    // Raster state
    // ------------------------------------------------------------------
    logic [CW-1:0] r_col_count,   n_col_count;
    logic [CW-1:0] r_row_count,   n_row_count;
    logic [PB-1:0] r_row_phase1,  n_row_phase1;
    logic [PB-1:0] r_row_phase2,  n_row_phase2;
    logic [PB-1:0] r_pix_phase1,  n_pix_phase1;
    logic [PB-1:0] r_pix_phase2,  n_pix_phase2;

    logic          in_accept;
    logic          restart;
    logic [CW-1:0] cur_col;
    logic [CW-1:0] cur_row;
    logic [PB-1:0] cur_row_phase1;
    logic [PB-1:0] cur_row_phase2;
    logic [PB-1:0] cur_pix_phase1;
    logic [PB-1:0] cur_pix_phase2;
    logic          eol;
    logic          eof;

    logic          r_out_valid;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign restart    = i_s_tdata[0];

    // Restart clears the raster before this pixel is produced
    assign cur_col        = restart ? '0 : r_col_count;
    assign cur_row        = restart ? '0 : r_row_count;
    assign cur_row_phase1 = restart ? '0 : r_row_phase1;
    assign cur_row_phase2 = restart ? '0 : r_row_phase2;
    assign cur_pix_phase1 = restart ? '0 : r_pix_phase1;
    assign cur_pix_phase2 = restart ? '0 : r_pix_phase2;

    // A counter at or past the last index closes its line (or frame)
    assign eol = (cur_col >= last_col);
    assign eof = eol && (cur_row >= last_row);

    always_comb begin
        n_col_count  = cur_col;
        n_row_count  = cur_row;
        n_row_phase1 = cur_row_phase1;
        n_row_phase2 = cur_row_phase2;
        n_pix_phase1 = cur_pix_phase1;
        n_pix_phase2 = cur_pix_phase2;
        if (eof) begin
            n_col_count  = '0;
            n_row_count  = '0;
            n_row_phase1 = '0;
            n_row_phase2 = '0;
            n_pix_phase1 = '0;
            n_pix_phase2 = '0;
        end else if (eol) begin
            // advance the row phases and reload the pixel phases from them
            n_col_count  = '0;
            n_row_count  = cur_row + CW'(1);
            n_row_phase1 = PB'(cur_row_phase1 + r_t1_step_y);
            n_row_phase2 = PB'(cur_row_phase2 + r_t2_step_y);
            n_pix_phase1 = n_row_phase1;
            n_pix_phase2 = n_row_phase2;
        end else begin
            n_col_count  = cur_col + CW'(1);
            n_pix_phase1 = PB'(cur_pix_phase1 + r_t1_step_x);
            n_pix_phase2 = PB'(cur_pix_phase2 + r_t2_step_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count  <= '0;
            r_row_count  <= '0;
            r_row_phase1 <= '0;
            r_row_phase2 <= '0;
            r_pix_phase1 <= '0;
            r_pix_phase2 <= '0;
        end else if (in_accept) begin
            r_col_count  <= n_col_count;
            r_row_count  <= n_row_count;
            r_row_phase1 <= n_row_phase1;
            r_row_phase2 <= n_row_phase2;
            r_pix_phase1 <= n_pix_phase1;
            r_pix_phase2 <= n_pix_phase2;
        end
    end

    // ------------------------------------------------------------------
    // Pixel value: one term, or the floored mean of two
    // ------------------------------------------------------------------
    logic [PW-1:0] mag1;
    logic [PW-1:0] mag2;
    logic [PW:0]   mag_sum;
    logic [PW-1:0] pixel;

    cgpg_cos_lut u_lut_term1 (
        .i_phase (cur_pix_phase1),
        .o_mag   (mag1)
    );

    cgpg_cos_lut u_lut_term2 (
        .i_phase (cur_pix_phase2),
        .o_mag   (mag2)
    );

    assign mag_sum = {1'b0, mag1} + {1'b0, mag2};
    assign pixel   = r_mode ? mag_sum[PW:1] : mag1;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PW-1:0] r_pixel;
    logic [CW-1:0] r_out_col;
    logic [CW-1:0] r_out_row;
    logic          r_out_eol;
    logic          r_out_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pixel   <= pixel;
            r_out_col <= cur_col;
            r_out_row <= cur_row;
            r_out_eol <= eol;
            r_out_eof <= eof;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_row, r_out_col, r_pixel};
    assign o_m_tlast  = r_out_eol;
    assign o_m_tuser  = r_out_eof;

endmodule

`default_nettype wire

// ===== rtl/core/cgpg_checker.sv =====
// ----------------------------------------------------------------------------
// cgpg_checker
// Port-level checks of the cosine grating pattern generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cgpg_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,
    input  wire logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [31:0]                       o_m_tdata,
    input  wire logic                              o_m_tlast,
    input  wire logic                              o_m_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("pixel valid after reset");

    // a stalled pixel keeps its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled pixel changed");

    // every accepted request shows its pixel in the next cycle
    a_req_to_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted request produced no pixel");

    // restart places the pixel at column zero, row zero
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[0] |=> o_m_tdata[31:8] == 24'd0)
        else $error("restart pixel not at origin");

    // the frame end is always also a line end
    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("end of frame without end of line");

endmodule

bind cosine_grating_pattern_generator cgpg_checker u_cgpg_checker (.*);

`default_nettype wire
